// ===== rtl/tlsf_pkg.sv =====
package tlsf_pkg;

  // Bin geometry and address width
  localparam int unsigned SL_BITS    = 5;
  localparam int unsigned FL_TOP     = 31;
  localparam int unsigned ADDR_WIDTH = 32;

  // Bitmap word width and table sizes (fixed by the 5-bit bin indexes)
  localparam int unsigned MAP_W      = 32;
  localparam int unsigned FL_COUNT   = 32;
  localparam int unsigned HEAD_DEPTH = 1024;
  localparam int unsigned HEAD_AW    = $clog2(HEAD_DEPTH);

  typedef logic [ADDR_WIDTH-1:0] addr_t;

  // Request function codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_SEARCH = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] req_size;
    logic [4:0]  fl_index;
    logic [4:0]  sl_index;
    logic [31:0] block_addr;
    logic [31:0] succ_addr;
    logic        succ_present;
  } tlsf_req_t;

  typedef struct packed {
    logic        found;
    logic [4:0]  fl_out;
    logic [4:0]  sl_out;
    logic [31:0] head_out;
    logic        bin_emptied;
  } tlsf_rsp_t;

  typedef enum logic [1:0] {
    RSP_NONE,
    RSP_REMOVE,
    RSP_FOUND
  } rsp_kind_e;

  // Controller -> datapath
  typedef struct packed {
    logic      cap;       // capture request, map size, start head read for remove
    logic      ins;       // commit insert
    logic      rm;        // commit remove
    logic      srch;      // one search step: second-level bitmap, first-level class on a miss
    logic      rsp_load;  // load the output register
    rsp_kind_e rsp_kind;
  } tlsf_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic l2_hit;
    logic l1_hit;
    logic out_free;
  } tlsf_stat_t;

endpackage

// ===== rtl/tlsf_free_bin_index_unit.sv =====
// Work per request: insert, remove and an unused code load their result from a
//   single work state; a search steps the second-level bitmap, moves up to a
//   higher first-level class on a miss, then loads after the head read or empty.
// One request at a time: the next one is accepted the cycle after its
//   predecessor's result is loaded; a held output register delays that load.
// Reset clears both bitmaps, the controller and the output valid; the head
//   table is not cleared and holds nothing until written.
module tlsf_free_bin_index_unit import tlsf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  tlsf_req_t in_req_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output tlsf_rsp_t out_rsp_o
);

  tlsf_cmd_t  cmd;
  tlsf_stat_t stat;

  // Controller: decodes the request function at accept and walks through
  // insert, remove (compare against the head read), the search steps or a no-op.
  tlsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_req_i.func),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: bitmaps, size mapping, head table and the output register.
  // The output register lets a finished result wait for out_ready_i while
  // the next request is taken in.
  tlsf_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_req_i    (in_req_i),
    .out_ready_i (out_ready_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o)
  );

  // Ready drops in the cycle after a request is accepted
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high right after accepting a request");

  // A fresh result only ends work on an accepted request
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared with no request in work");

  // A miss or a non-search result carries no bin or head
  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.found |->
      out_rsp_o.fl_out == 5'd0 && out_rsp_o.sl_out == 5'd0 && out_rsp_o.head_out == 32'd0)
    else $error("nonzero bin fields without found");

  a_kind_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.found && out_rsp_o.bin_emptied))
    else $error("found and bin_emptied both set");

endmodule

// ===== rtl/tlsf_ctrl.sv =====
module tlsf_ctrl import tlsf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_func_i,
  output logic       in_ready_o,
  input  tlsf_stat_t stat_i,
  output tlsf_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_INS  = 3'd1;
  localparam logic [2:0] ST_RM   = 3'd2;
  localparam logic [2:0] ST_L2   = 3'd3;
  localparam logic [2:0] ST_HEAD = 3'd4;
  localparam logic [2:0] ST_NOP  = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.rsp_kind = RSP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          unique case (in_func_i)
            FUNC_INSERT: state_d = ST_INS;
            FUNC_REMOVE: state_d = ST_RM;
            FUNC_SEARCH: state_d = ST_L2;
            default:     state_d = ST_NOP;
          endcase
        end
      end
      ST_INS: begin
        if (stat_i.out_free) begin
          cmd_o.ins      = 1'b1;
          cmd_o.rsp_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_RM: begin
        if (stat_i.out_free) begin
          cmd_o.rm       = 1'b1;
          cmd_o.rsp_load = 1'b1;
          cmd_o.rsp_kind = RSP_REMOVE;
          state_d        = ST_IDLE;
        end
      end
      ST_L2: begin
        cmd_o.srch = 1'b1;
        if (stat_i.l2_hit) begin
          state_d = ST_HEAD;
        end else if (!stat_i.l1_hit && stat_i.out_free) begin
          // nothing large enough: empty result
          cmd_o.rsp_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_HEAD: begin
        if (stat_i.out_free) begin
          cmd_o.rsp_load = 1'b1;
          cmd_o.rsp_kind = RSP_FOUND;
          state_d        = ST_IDLE;
        end
      end
      ST_NOP: begin
        if (stat_i.out_free) begin
          cmd_o.rsp_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/tlsf_dp.sv =====
module tlsf_dp import tlsf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tlsf_cmd_t  cmd_i,
  input  tlsf_req_t  in_req_i,
  input  logic       out_ready_i,
  output tlsf_stat_t stat_o,
  output logic       out_valid_o,
  output tlsf_rsp_t  out_rsp_o
);

  localparam logic [5:0] SlCount = 6'(1 << SL_BITS);

  // lowest set bit, 31 when none
  function automatic logic [4:0] low_bit(input logic [MAP_W-1:0] v);
    logic [4:0] n;
    n = 5'd31;
    for (int i = MAP_W - 2; i >= 0; i--) begin
      if (v[i]) n = 5'(i);
    end
    return n;
  endfunction

  function automatic logic [4:0] high_bit(input logic [31:0] v);
    logic [4:0] n;
    n = 5'd0;
    for (int i = 1; i < 32; i++) begin
      if (v[i]) n = 5'(i);
    end
    return n;
  endfunction

  logic [MAP_W-1:0] l1_q;
  logic [MAP_W-1:0] l2_q [FL_COUNT];
  addr_t            heads [HEAD_DEPTH];
  addr_t            rd_q;
  tlsf_req_t        req_q;
  logic [4:0]       f_q, s_q, fnd_fl_q, fnd_sl_q;
  logic             out_valid_q;
  tlsf_rsp_t        rsp_q, rsp_d;

  // size to bin mapping, done on the incoming request
  logic [31:0] size, shifted;
  logic [4:0]  hb, sh, map_f, map_s;
  logic [5:0]  s_raw, f_raw;
  logic        round_up;

  always_comb begin
    size     = in_req_i.req_size;
    hb       = high_bit(size);
    sh       = hb - 5'(SL_BITS);
    shifted  = size >> sh;
    round_up = |(size & ~(32'hFFFF_FFFF << sh));
    s_raw    = {1'b0, 5'(shifted[SL_BITS-1:0])};
    f_raw    = {1'b0, hb};
    if (round_up) s_raw = s_raw + 6'd1;
    if (s_raw >= SlCount) begin
      f_raw = f_raw + 6'd1;
      s_raw = '0;
    end
    if (f_raw > 6'(FL_TOP)) f_raw = 6'(FL_TOP);
    if (size < 32'(SlCount)) begin
      map_f = '0;
      map_s = 5'(size);
    end else begin
      map_f = f_raw[4:0];
      map_s = s_raw[4:0];
    end
  end

  // bitmap lookups
  logic [4:0]       l2_addr, s_lo, f_lo;
  logic [MAP_W-1:0] l2_word, avail_sl, avail_fl, l2_clr;
  logic             l2_hit, l1_hit, bin_ok, rm_match;

  assign l2_addr  = cmd_i.srch ? f_q : req_q.fl_index;
  assign l2_word  = l2_q[l2_addr];
  assign avail_sl = l2_word & ({MAP_W{1'b1}} << s_q);
  assign l2_hit   = |avail_sl;
  assign s_lo     = low_bit(avail_sl);
  // shift of 32 empties the mask
  assign avail_fl = l1_q & ({MAP_W{1'b1}} << ({1'b0, f_q} + 6'd1));
  assign l1_hit   = |avail_fl;
  assign f_lo     = low_bit(avail_fl);

  assign bin_ok   = (req_q.fl_index <= 5'(FL_TOP)) && ({1'b0, req_q.sl_index} < SlCount);
  assign rm_match = bin_ok && l2_word[req_q.sl_index] &&
                    (rd_q == ADDR_WIDTH'(req_q.block_addr));
  assign l2_clr   = l2_word & ~(MAP_W'(1) << req_q.sl_index);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q <= '0;
      for (int i = 0; i < FL_COUNT; i++) l2_q[i] <= '0;
    end else begin
      if (cmd_i.ins && bin_ok) begin
        l1_q[req_q.fl_index]                 <= 1'b1;
        l2_q[req_q.fl_index][req_q.sl_index] <= 1'b1;
      end
      if (cmd_i.rm && rm_match && !req_q.succ_present) begin
        l2_q[req_q.fl_index] <= l2_clr;
        if (l2_clr == '0) l1_q[req_q.fl_index] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      req_q <= in_req_i;
      f_q   <= map_f;
      s_q   <= map_s;
    end else if (cmd_i.srch && !l2_hit && l1_hit) begin
      f_q <= f_lo;
      s_q <= '0;
    end
    if (cmd_i.srch && l2_hit) begin
      fnd_fl_q <= f_q;
      fnd_sl_q <= s_lo;
    end
  end

  // head table: one write, one registered read per cycle
  logic               mem_we, mem_re;
  logic [HEAD_AW-1:0] wr_idx, rd_idx;
  addr_t              wr_data;

  assign mem_we  = (cmd_i.ins && bin_ok) || (cmd_i.rm && rm_match && req_q.succ_present);
  assign wr_idx  = {req_q.fl_index, req_q.sl_index};
  assign wr_data = cmd_i.ins ? ADDR_WIDTH'(req_q.block_addr) : ADDR_WIDTH'(req_q.succ_addr);
  assign mem_re  = (cmd_i.cap && in_req_i.func == FUNC_REMOVE) || (cmd_i.srch && l2_hit);
  assign rd_idx  = cmd_i.cap ? {in_req_i.fl_index, in_req_i.sl_index} : {f_q, s_lo};

  always_ff @(posedge clk_i) begin
    if (mem_we) heads[wr_idx] <= wr_data;
    if (mem_re) rd_q <= heads[rd_idx];
  end

  // output register
  always_comb begin
    rsp_d = '0;
    unique case (cmd_i.rsp_kind)
      RSP_NONE: ;
      RSP_REMOVE: rsp_d.bin_emptied = rm_match && !req_q.succ_present;
      RSP_FOUND: begin
        rsp_d.found    = 1'b1;
        rsp_d.fl_out   = fnd_fl_q;
        rsp_d.sl_out   = fnd_sl_q;
        rsp_d.head_out = 32'(rd_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.rsp_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rsp_load) rsp_q <= rsp_d;
  end

  assign stat_o.l2_hit   = l2_hit;
  assign stat_o.l1_hit   = l1_hit;
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_rsp_o       = rsp_q;

endmodule
